// ----- sv/apf_pkg.sv -----
// Shared types and constants for the all-pole IIR filter.
package apf_pkg;

    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned COEF_W       = 16;
    localparam int unsigned PROD_W       = SAMPLE_W + COEF_W;
    localparam int unsigned ACC_W        = 36;
    localparam int unsigned FRAC_SHIFT   = 12;
    localparam int unsigned ROUND_BIAS   = 2048;
    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned COEF_GROUPS  = 3;
    localparam int unsigned LANES        = 4;
    localparam int unsigned ORDER_DEFAULT = 12;

    localparam logic [SAMPLE_W-1:0] GAIN_RESET = 16'h1000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // latch the input sample, clear the accumulator
        logic mul;    // form the product for the current tap
        logic acc;    // fold the registered product into the accumulator
        logic fin;    // round, saturate, present the result, shift history
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a new result this cycle
    } t_dp_sts;

endpackage

// ----- sv/apf_ctrl.sv -----
// Sequencer for the all-pole IIR filter: steps the shared multiplier over the taps.
module apf_ctrl #(
    parameter int unsigned FILTER_ORDER = apf_pkg::ORDER_DEFAULT,
    parameter int unsigned TAP_W        = $clog2(FILTER_ORDER + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  apf_pkg::t_dp_sts i_sts,
    output logic             o_in_stall,
    output apf_pkg::t_dp_cmd o_cmd,
    output logic [TAP_W-1:0] o_tap
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(FILTER_ORDER);

    logic [1:0]       r_state, n_state;
    logic [TAP_W-1:0] r_tap, n_tap;

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_tap      = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.acc = (r_tap != '0);
                if (r_tap == TAP_LAST) begin
                    n_state = S_LAST;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            S_LAST: begin
                o_cmd.acc = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_tap      = r_tap;

endmodule

// ----- sv/apf_dp.sv -----
// Datapath for the all-pole IIR filter: config registers, history, MAC and output register.
module apf_dp #(
    parameter int unsigned FILTER_ORDER = apf_pkg::ORDER_DEFAULT,
    parameter int unsigned TAP_W        = $clog2(FILTER_ORDER + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [apf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [apf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [apf_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                i_out_stall,
    input  apf_pkg::t_dp_cmd                    i_cmd,
    input  logic [TAP_W-1:0]                    i_tap,
    output apf_pkg::t_dp_sts                    o_sts,
    output logic                                o_out_valid,
    output logic signed [apf_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_clipped
);

    localparam int unsigned SW   = apf_pkg::SAMPLE_W;
    localparam int unsigned SH_W = apf_pkg::ACC_W - apf_pkg::FRAC_SHIFT;
    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(32767);
    localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-32768);

    logic [apf_pkg::CFG_DATA_W-1:0]        r_coef [apf_pkg::COEF_GROUPS];
    logic signed [SW-1:0]                  r_gain;
    logic signed [SW-1:0]                  r_hist [FILTER_ORDER];
    logic signed [SW-1:0]                  r_x;
    logic signed [apf_pkg::PROD_W-1:0]     r_prod;
    logic                                  r_sub;
    logic signed [apf_pkg::ACC_W-1:0]      r_acc;
    logic                                  r_ovalid;
    logic signed [SW-1:0]                  r_y;
    logic                                  r_clip;

    logic signed [SW-1:0]                  op_a, op_b;
    logic signed [apf_pkg::ACC_W-1:0]      prod_ext, rnd;
    logic signed [SH_W-1:0]                sh;
    logic signed [SW-1:0]                  y_sat;
    logic                                  clip;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < apf_pkg::COEF_GROUPS; g++) begin
                r_coef[g] <= '0;
            end
            r_gain <= apf_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                apf_pkg::CFG_COEF_LO:  r_coef[0] <= i_cfg_data;
                apf_pkg::CFG_COEF_MID: r_coef[1] <= i_cfg_data;
                apf_pkg::CFG_COEF_HI:  r_coef[2] <= i_cfg_data;
                apf_pkg::CFG_GAIN:     r_gain    <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // Operand select: tap 0 is the gained input, tap k is history k-1
    always_comb begin
        op_a = r_x;
        op_b = r_gain;
        for (int i = 0; i < FILTER_ORDER; i++) begin
            if (i_tap == TAP_W'(i + 1)) begin
                op_a = r_hist[i];
                op_b = r_coef[i >> 2][16 * (i & 3) +: 16];
            end
        end
    end

    assign prod_ext = apf_pkg::ACC_W'(r_prod);
    assign rnd      = r_acc + apf_pkg::ACC_W'(apf_pkg::ROUND_BIAS);
    assign sh       = rnd[apf_pkg::ACC_W-1:apf_pkg::FRAC_SHIFT];

    always_comb begin
        clip  = 1'b0;
        y_sat = sh[SW-1:0];
        if (sh > SAT_HI) begin
            y_sat = SAT_HI[SW-1:0];
            clip  = 1'b1;
        end else if (sh < SAT_LO) begin
            y_sat = SAT_LO[SW-1:0];
            clip  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mul) begin
            r_prod <= op_a * op_b;
            r_sub  <= (i_tap != '0);
        end
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= r_sub ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end
        if (i_cmd.fin) begin
            r_y    <= y_sat;
            r_clip <= clip;
        end
    end

    // Output history, newest at entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FILTER_ORDER; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_cmd.fin) begin
            r_hist[0] <= y_sat;
            for (int i = 1; i < FILTER_ORDER; i++) begin
                r_hist[i] <= r_hist[i - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_ovalid || !i_out_stall;
    assign o_out_valid    = r_ovalid;
    assign o_sample_out   = r_y;
    assign o_clipped      = r_clip;

endmodule

// ----- sv/all_pole_iir_filter.sv -----
// The single shared 16x16 multiplier visits the gain tap and every pole tap in turn; the
// input stays stalled until a taken sample's result is committed to the output register.
// A finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active low) zeroes the history and coefficients, sets gain to 1.0
// and empties the output register.
module all_pole_iir_filter #(
    parameter int unsigned FILTER_ORDER = apf_pkg::ORDER_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [apf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [apf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [apf_pkg::SAMPLE_W-1:0] i_sample_in,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [apf_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_clipped
);

    // Tap counter runs 0 (gain) through FILTER_ORDER (oldest pole tap)
    localparam int unsigned TAP_W = $clog2(FILTER_ORDER + 1);

    apf_pkg::t_dp_cmd cmd;
    apf_pkg::t_dp_sts sts;
    logic [TAP_W-1:0] tap;

    // Controller: take a transaction in idle, step the multiplier, then wait for room
    // in the output register before committing the result to history.
    apf_ctrl #(
        .FILTER_ORDER (FILTER_ORDER),
        .TAP_W        (TAP_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .o_tap      (tap)
    );

    // Datapath: one registered product per cycle while the taps are stepped, feeding a wide accumulator; the
    // round and saturate step feeds both the output register and the history line.
    apf_dp #(
        .FILTER_ORDER (FILTER_ORDER),
        .TAP_W        (TAP_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_out_stall  (i_out_stall),
        .i_cmd        (cmd),
        .i_tap        (tap),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule

// ----- sv/apf_checker.sv -----
// Port-level checks for the all-pole IIR filter, bound to the top level.
module apf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [apf_pkg::SAMPLE_W-1:0] o_sample_out,
    input logic                                o_clipped
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // A stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_sample_out) && $stable(o_clipped))
        else $error("output payload changed while stalled");

    // Taking a sample starts the tap sequence, so the input is held off next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a transaction");

    // Clipping only ever reports a rail value
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |->
            (o_sample_out == 16'sh7fff) || (o_sample_out == 16'sh8000))
        else $error("clip flag set on a non-rail sample");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind all_pole_iir_filter apf_checker u_apf_checker (.*);
